@@ rtl/core/fpg_pkg.sv @@
// Shared constants, mode codes and the lane control struct for the fade and pan gain stage.
// Used by fpg_lane and fade_pan_gain_stage; depends on nothing else.
`timescale 1ns / 1ps

package fpg_pkg;

    localparam int BLOCK_MAX   = 4096;
    localparam int SAMPLE_BITS = 24;
    localparam int LEN_W       = 13;
    localparam int IDX_W       = $clog2(BLOCK_MAX);
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int GAIN_W      = 31;
    localparam int STEP_W      = GAIN_W + 2;
    localparam int RAMP_W      = 45;
    localparam int ACC_W       = 64;
    localparam int FRAC_SHIFT  = 27;
    localparam int DIV_STEPS   = GAIN_W;
    localparam int MUL_STEPS   = SAMPLE_BITS;
    localparam int CNT_W       = $clog2(DIV_STEPS);

    localparam logic [CFG_W-1:0]       UNITY_PAN  = 16'd32768;
    localparam logic [LEN_W-1:0]       LEN_MAX    = LEN_W'(BLOCK_MAX);
    localparam logic [LEN_W-1:0]       LEN_MIN    = LEN_W'(1);
    localparam logic [ACC_W-1:0]       ROUND_HALF = ACC_W'(1) << (FRAC_SHIFT - 1);
    localparam logic [SAMPLE_BITS-1:0] SAT_MAX    = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAT_MIN    = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] CFG_MASTER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAN_LEFT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAN_RIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_CH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_CH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EN_CH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN = 3'd6;

    localparam logic [1:0] CH_MONO   = 2'd1;
    localparam logic [1:0] CH_STEREO = 2'd2;
    localparam logic [1:0] EN_RIGHT  = 2'd1;
    localparam logic [1:0] EN_STEREO = 2'd2;

    typedef enum logic [1:0] {
        MODE_INACTIVE = 2'd0,
        MODE_ACTIVE   = 2'd1,
        MODE_FADE_IN  = 2'd2,
        MODE_FADE_OUT = 2'd3
    } t_mode;

    typedef struct packed {
        logic prod;
        logic div_step;
        logic ramp_load;
        logic mul_load;
        logic mul_step;
        logic mul_last;
        logic advance;
    } t_lane_ctl;

endpackage

@@ rtl/core/fpg_lane.sv @@
// One gain channel: block gain product, serial ramp step divider, ramp accumulator
// and a bit-serial sample multiplier with rounding and saturation. Depends on fpg_pkg.
`timescale 1ns / 1ps

module fpg_lane (
    input  logic                            i_clk,
    input  fpg_pkg::t_lane_ctl              i_ctl,
    input  fpg_pkg::t_mode                  i_mode,
    input  logic [fpg_pkg::CFG_W-1:0]       i_master,
    input  logic [fpg_pkg::CFG_W-1:0]       i_pan,
    input  logic [fpg_pkg::LEN_W-1:0]       i_len,
    input  logic [fpg_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic [fpg_pkg::SAMPLE_BITS-1:0] o_result
);
    import fpg_pkg::*;

    logic [GAIN_W-1:0]      r_full;
    logic [GAIN_W-1:0]      r_dvd;
    logic [GAIN_W-1:0]      r_quo;
    logic [LEN_W-1:0]       r_rem;
    logic [STEP_W-1:0]      r_step;
    logic [RAMP_W-1:0]      r_gain;
    logic [ACC_W-1:0]       r_acc;
    logic [ACC_W-1:0]       r_mcand;
    logic [SAMPLE_BITS-1:0] r_smp;

    logic [2*CFG_W-1:0]     prod;
    logic [GAIN_W-1:0]      gain_full;
    logic [LEN_W:0]         rem_sh;
    logic [LEN_W:0]         rem_diff;
    logic                   q_bit;
    logic [STEP_W-1:0]      step_mag;
    logic [ACC_W-1:0]       addend;
    logic [ACC_W-FRAC_SHIFT-SAMPLE_BITS:0] upper;
    logic                   ovf;

    assign prod      = (2*CFG_W)'(i_master) * (2*CFG_W)'(i_pan);
    assign gain_full = (i_mode == MODE_INACTIVE) ? '0 : prod[GAIN_W-1:0];
    assign rem_sh    = {r_rem, r_dvd[GAIN_W-1]};
    assign rem_diff  = rem_sh - {1'b0, i_len};
    assign q_bit     = (rem_sh >= {1'b0, i_len});
    assign step_mag  = {{(STEP_W - GAIN_W){1'b0}}, r_quo};

    always_comb begin
        if (!r_smp[0]) begin
            addend = '0;
        end else if (i_ctl.mul_last) begin
            addend = '0 - r_mcand;
        end else begin
            addend = r_mcand;
        end
    end

    // The result fits when every bit above its sign bit matches it.
    assign upper    = r_acc[ACC_W-1:FRAC_SHIFT+SAMPLE_BITS-1];
    assign ovf      = (|upper) && !(&upper);
    assign o_result = ovf ? (r_acc[ACC_W-1] ? SAT_MIN : SAT_MAX)
                          : r_acc[FRAC_SHIFT+SAMPLE_BITS-1:FRAC_SHIFT];

    always_ff @(posedge i_clk) begin
        if (i_ctl.prod) begin
            r_full <= gain_full;
            r_dvd  <= gain_full;
            r_rem  <= '0;
            r_quo  <= '0;
        end else if (i_ctl.div_step) begin
            r_dvd <= {r_dvd[GAIN_W-2:0], 1'b0};
            r_rem <= q_bit ? rem_diff[LEN_W-1:0] : rem_sh[LEN_W-1:0];
            r_quo <= {r_quo[GAIN_W-2:0], q_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ramp_load) begin
            unique case (i_mode)
                MODE_FADE_IN: begin
                    r_gain <= '0;
                    r_step <= step_mag;
                end
                MODE_FADE_OUT: begin
                    r_gain <= RAMP_W'(r_full);
                    r_step <= '0 - step_mag;
                end
                default: begin
                    r_gain <= RAMP_W'(r_full);
                    r_step <= '0;
                end
            endcase
        end else if (i_ctl.advance) begin
            r_gain <= r_gain + {{(RAMP_W - STEP_W){r_step[STEP_W-1]}}, r_step};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_load) begin
            r_acc   <= ROUND_HALF;
            r_mcand <= {{(ACC_W - RAMP_W){r_gain[RAMP_W-1]}}, r_gain};
            r_smp   <= i_sample;
        end else if (i_ctl.mul_step) begin
            r_acc   <= r_acc + addend;
            r_mcand <= {r_mcand[ACC_W-2:0], 1'b0};
            r_smp   <= {1'b0, r_smp[SAMPLE_BITS-1:1]};
        end
    end

endmodule

@@ rtl/core/fade_pan_gain_stage.sv @@
// Top level of the fade and pan gain stage: configuration registers, sequencer,
// routing and output register. Depends on fpg_pkg and fpg_lane.
//
//   channel  handshake                   payload
//   cfg      i_cfg_we                    i_cfg_idx, i_cfg_data
//   in       i_in_valid / o_in_ready     i_func, i_sample_left, i_sample_right,
//                                        i_active_request
//   out      o_out_valid / i_out_ready   o_out_left, o_out_right, o_block_end
//
// A set-active item is taken in the idle state. A frame passes the prepare state, the
// 24-step bit-serial multiplier and the output state; the first frame of a block first
// passes the gain product, the 31-step ramp step divider and the ramp load state.
// Reset is synchronous and active low; no clearing pass is needed.
// A finished result waits in the output register while the next item is accepted;
// the following frame stalls in its last cycle until that register is free.
`timescale 1ns / 1ps

module fade_pan_gain_stage (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [fpg_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [fpg_pkg::CFG_W-1:0]              i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_func,
    input  logic signed [fpg_pkg::SAMPLE_BITS-1:0] i_sample_left,
    input  logic signed [fpg_pkg::SAMPLE_BITS-1:0] i_sample_right,
    input  logic                                   i_active_request,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [fpg_pkg::SAMPLE_BITS-1:0] o_out_left,
    output logic signed [fpg_pkg::SAMPLE_BITS-1:0] o_out_right,
    output logic                                   o_block_end
);
    import fpg_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_GAIN = 7'b0000010,
        ST_DIV  = 7'b0000100,
        ST_RAMP = 7'b0001000,
        ST_PREP = 7'b0010000,
        ST_MUL  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } t_state;

    logic [CFG_W-1:0]       r_master;
    logic [CFG_W-1:0]       r_pan_l;
    logic [CFG_W-1:0]       r_pan_r;
    logic [1:0]             r_in_ch;
    logic [1:0]             r_out_ch;
    logic [1:0]             r_en_ch;
    logic [LEN_W-1:0]       r_block_len;

    t_state                 r_state;
    t_state                 n_state;
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       n_cnt;
    logic                   r_is_active;
    t_mode                  r_pending;
    t_mode                  r_block_mode;
    logic [IDX_W-1:0]       r_fi;
    logic [SAMPLE_BITS-1:0] r_smp_l;
    logic [SAMPLE_BITS-1:0] r_smp_r;
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_l;
    logic [SAMPLE_BITS-1:0] r_out_r;
    logic                   r_blk_end;

    logic                   in_accept;
    logic                   out_free;
    logic                   pan_req;
    logic                   src_right;
    logic [LEN_W-1:0]       eff_len;
    logic [LEN_W-1:0]       fi_next;
    logic                   blk_end;
    logic [CFG_W-1:0]       pg_l;
    logic [CFG_W-1:0]       pg_r;
    logic [SAMPLE_BITS-1:0] src_smp;
    logic [SAMPLE_BITS-1:0] smp0;
    logic [SAMPLE_BITS-1:0] smp1;
    logic [SAMPLE_BITS-1:0] res0;
    logic [SAMPLE_BITS-1:0] res1;
    t_lane_ctl              lane_ctl;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    assign pan_req   = (r_out_ch == CH_STEREO) && ((r_in_ch == CH_MONO) || (r_en_ch < EN_STEREO));
    assign src_right = (r_in_ch != CH_MONO) && (r_en_ch == EN_RIGHT);
    assign pg_l      = !pan_req ? UNITY_PAN : ((r_pan_l > UNITY_PAN) ? UNITY_PAN : r_pan_l);
    assign pg_r      = !pan_req ? UNITY_PAN : ((r_pan_r > UNITY_PAN) ? UNITY_PAN : r_pan_r);
    assign src_smp   = src_right ? r_smp_r : r_smp_l;
    assign smp0      = pan_req ? src_smp : r_smp_l;
    assign smp1      = pan_req ? src_smp : r_smp_r;

    always_comb begin
        if (r_block_len == '0) begin
            eff_len = LEN_MIN;
        end else if (r_block_len > LEN_MAX) begin
            eff_len = LEN_MAX;
        end else begin
            eff_len = r_block_len;
        end
    end

    assign fi_next = LEN_W'(r_fi) + LEN_MIN;
    assign blk_end = (fi_next >= eff_len);

    assign lane_ctl.prod      = (r_state == ST_GAIN);
    assign lane_ctl.div_step  = (r_state == ST_DIV);
    assign lane_ctl.ramp_load = (r_state == ST_RAMP);
    assign lane_ctl.mul_load  = (r_state == ST_PREP);
    assign lane_ctl.mul_step  = (r_state == ST_MUL);
    assign lane_ctl.mul_last  = (r_state == ST_MUL) && (r_cnt == CNT_W'(MUL_STEPS - 1));
    assign lane_ctl.advance   = (r_state == ST_OUT) && out_free;

    fpg_lane u_lane_left (
        .i_clk    (i_clk),
        .i_ctl    (lane_ctl),
        .i_mode   (r_block_mode),
        .i_master (r_master),
        .i_pan    (pg_l),
        .i_len    (eff_len),
        .i_sample (smp0),
        .o_result (res0)
    );

    fpg_lane u_lane_right (
        .i_clk    (i_clk),
        .i_ctl    (lane_ctl),
        .i_mode   (r_block_mode),
        .i_master (r_master),
        .i_pan    (pg_r),
        .i_len    (eff_len),
        .i_sample (smp1),
        .o_result (res1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master    <= 16'd4096;
            r_pan_l     <= 16'd23170;
            r_pan_r     <= 16'd23170;
            r_in_ch     <= CH_STEREO;
            r_out_ch    <= CH_STEREO;
            r_en_ch     <= EN_STEREO;
            r_block_len <= 13'd512;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MASTER:    r_master    <= i_cfg_data;
                CFG_PAN_LEFT:  r_pan_l     <= i_cfg_data;
                CFG_PAN_RIGHT: r_pan_r     <= i_cfg_data;
                CFG_IN_CH:     r_in_ch     <= i_cfg_data[1:0];
                CFG_OUT_CH:    r_out_ch    <= i_cfg_data[1:0];
                CFG_EN_CH:     r_en_ch     <= i_cfg_data[1:0];
                CFG_BLOCK_LEN: r_block_len <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept && !i_func) begin
                    n_state = (r_fi == '0) ? ST_GAIN : ST_PREP;
                end
            end
            ST_GAIN: begin
                n_state = ST_DIV;
                n_cnt   = '0;
            end
            ST_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_RAMP;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_RAMP: begin
                n_state = ST_PREP;
            end
            ST_PREP: begin
                n_state = ST_MUL;
                n_cnt   = '0;
            end
            ST_MUL: begin
                if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                    n_state = ST_OUT;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_is_active  <= 1'b0;
            r_pending    <= MODE_INACTIVE;
            r_block_mode <= MODE_INACTIVE;
            r_fi         <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (in_accept && i_func) begin
                if (i_active_request != r_is_active) begin
                    r_pending   <= i_active_request ? MODE_FADE_IN : MODE_FADE_OUT;
                    r_is_active <= i_active_request;
                end
            end else if (in_accept && (r_fi == '0)) begin
                r_block_mode <= r_pending;
                if (r_pending == MODE_FADE_IN) begin
                    r_pending <= MODE_ACTIVE;
                end else if (r_pending == MODE_FADE_OUT) begin
                    r_pending <= MODE_INACTIVE;
                end
            end
            if (lane_ctl.advance) begin
                r_fi <= blk_end ? '0 : fi_next[IDX_W-1:0];
            end
            if (lane_ctl.advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_smp_l <= i_sample_left;
            r_smp_r <= i_sample_right;
        end
        if (lane_ctl.advance) begin
            r_out_l   <= res0;
            r_out_r   <= (r_out_ch == CH_STEREO) ? res1 : '0;
            r_blk_end <= blk_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_left  = r_out_l;
    assign o_out_right = r_out_r;
    assign o_block_end = r_blk_end;

endmodule

@@ rtl/core/fpg_checker.sv @@
// Port-level checks for the fade and pan gain stage, bound to the top level.
// Depends only on the ports of fade_pan_gain_stage.
`timescale 1ns / 1ps

module fpg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_func,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [23:0] o_out_left,
    input logic [23:0] o_out_right,
    input logic        o_block_end
);

    // A held result keeps its payload until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_out_left) && $stable(o_out_right)
             && $stable(o_block_end)))
        else $error("output item changed while stalled");

    // An accepted frame keeps the input closed while it is being computed.
    a_frame_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_func) |=> !o_in_ready)
        else $error("input ready during a frame");

    // A set-active item is absorbed at once and the input stays open.
    a_event_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_func) |=> o_in_ready)
        else $error("input closed after a set-active item");

    // No result can appear in the cycle right after an item is accepted.
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !o_out_valid) |=> !o_out_valid)
        else $error("result appeared too early");

    // The output register is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind fade_pan_gain_stage fpg_checker u_fpg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_func      (i_func),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_left  (o_out_left),
    .o_out_right (o_out_right),
    .o_block_end (o_block_end)
);

@@ tb/tb_fade_pan_gain_stage.sv @@
// Self-checking testbench for fade_pan_gain_stage: a directed plan of frames, set-active items
// and register writes, then random phases, checked against a model of the ramps and routing or fixed values.
// Depends on fpg_pkg and the fade_pan_gain_stage RTL.
`timescale 1ns / 1ps

module tb_fade_pan_gain_stage;
    import fpg_pkg::*;

    localparam logic       FN_FRAME      = 1'b0;
    localparam logic       FN_SET_ACTIVE = 1'b1;
    localparam logic [1:0] EN_LEFT       = 2'd0;
    localparam logic [1:0] CH_CODE_ZERO  = 2'd0;
    localparam logic [1:0] CH_CODE_THREE = 2'd3;
    localparam int         SETTLE_CYCLES = 80;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         PHASES        = 12;
    localparam int         PHASE_ITEMS   = 50;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_FRAME,
        ROW_EVENT
    } t_row_kind;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] left;
        logic [SAMPLE_BITS-1:0] right;
        logic                   block_end;
    } t_frame_out;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_W-1:0]       reg_val;
        logic [SAMPLE_BITS-1:0] left;
        logic [SAMPLE_BITS-1:0] right;
        logic                   request;
        logic                   typed;
        t_frame_out             want;
    } t_plan_row;

    logic                   i_clk            = 1'b0;
    logic                   i_rst_n          = 1'b0;
    logic                   i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx        = '0;
    logic [CFG_W-1:0]       i_cfg_data       = '0;
    logic                   i_in_valid       = 1'b0;
    logic                   o_in_ready;
    logic                   i_func           = 1'b0;
    logic [SAMPLE_BITS-1:0] i_sample_left    = '0;
    logic [SAMPLE_BITS-1:0] i_sample_right   = '0;
    logic                   i_active_request = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_ready      = 1'b0;
    logic [SAMPLE_BITS-1:0] o_out_left;
    logic [SAMPLE_BITS-1:0] o_out_right;
    logic                   o_block_end;

    fade_pan_gain_stage uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_sample_left   (i_sample_left),
        .i_sample_right  (i_sample_right),
        .i_active_request(i_active_request),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_left      (o_out_left),
        .o_out_right     (o_out_right),
        .o_block_end     (o_block_end)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic [CFG_W-1:0] sh_master = 16'd4096;
    logic [CFG_W-1:0] sh_pan_l  = 16'd23170;
    logic [CFG_W-1:0] sh_pan_r  = 16'd23170;
    logic [1:0]       sh_in     = CH_STEREO;
    logic [1:0]       sh_out    = CH_STEREO;
    logic [1:0]       sh_en     = EN_STEREO;
    logic [LEN_W-1:0] sh_len    = 13'd512;

    logic             m_active      = 1'b0;
    t_mode            m_pending     = MODE_INACTIVE;
    t_mode            m_block       = MODE_INACTIVE;
    logic [IDX_W-1:0] m_pos         = '0;
    logic [31:0]      m_base [2]    = '{32'd0, 32'd0};
    longint           m_inc [2]     = '{64'sd0, 64'sd0};
    int               m_latched_len = 1;

    t_frame_out expected_frames [$];
    t_plan_row  plan [$];
    int         fail_count = 0;
    int         hold_req   = 0;
    int         hold_ack   = 0;
    int         hold_left  = 0;
    logic       idle_en    = 1'b1;

    function automatic int eff_len(input logic [LEN_W-1:0] len);
        if (len == '0) begin
            return 1;
        end
        if (len > LEN_MAX) begin
            return BLOCK_MAX;
        end
        return int'(len);
    endfunction

    function automatic bit pan_needed();
        return sh_out == CH_STEREO && (sh_in == CH_MONO || sh_en < EN_STEREO);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] apply_gain(input logic [SAMPLE_BITS-1:0] smp,
                                                          input longint gain);
        longint acc;
        longint hi;
        hi  = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        acc = (longint'($signed(smp)) * gain + (longint'(1) <<< (FRAC_SHIFT - 1)))
              >>> FRAC_SHIFT;
        if (acc > hi) begin
            return SAT_MAX;
        end
        if (acc < -hi - 1) begin
            return SAT_MIN;
        end
        return acc[SAMPLE_BITS-1:0];
    endfunction

    // Returns 1 when the item yields a frame, with the frame in res.
    function automatic bit advance_gain_model(input logic fn, input logic [SAMPLE_BITS-1:0] sl,
                                              input logic [SAMPLE_BITS-1:0] sr,
                                              input logic req, output t_frame_out res);
        int                     n;
        int                     c;
        int                     nxt;
        logic [CFG_W-1:0]       pg [2];
        longint                 g [2];
        logic [SAMPLE_BITS-1:0] src;
        res = '0;
        if (fn == FN_SET_ACTIVE) begin
            if (req != m_active) begin
                if (req) begin
                    m_pending = MODE_FADE_IN;
                end else begin
                    m_pending = MODE_FADE_OUT;
                end
                m_active = req;
            end
            return 1'b0;
        end
        if (m_pos == '0) begin
            n = eff_len(sh_len);
            m_latched_len = n;
            m_block = m_pending;
            if (m_block == MODE_FADE_IN) begin
                m_pending = MODE_ACTIVE;
            end else if (m_block == MODE_FADE_OUT) begin
                m_pending = MODE_INACTIVE;
            end
            pg[0] = (pan_needed() && sh_pan_l < UNITY_PAN) ? sh_pan_l : UNITY_PAN;
            pg[1] = (pan_needed() && sh_pan_r < UNITY_PAN) ? sh_pan_r : UNITY_PAN;
            for (c = 0; c < 2; c++) begin
                g[c] = (m_block == MODE_INACTIVE) ? 64'sd0
                                                  : longint'(sh_master) * longint'(pg[c]);
                case (m_block)
                    MODE_FADE_IN: begin
                        m_base[c] = '0;
                        m_inc[c]  = g[c] / n;
                    end
                    MODE_FADE_OUT: begin
                        m_base[c] = g[c][31:0];
                        m_inc[c]  = -(g[c] / n);
                    end
                    default: begin
                        m_base[c] = g[c][31:0];
                        m_inc[c]  = 0;
                    end
                endcase
            end
        end
        for (c = 0; c < 2; c++) begin
            g[c] = longint'(m_base[c]) + longint'(m_pos) * m_inc[c];
        end
        if (pan_needed()) begin
            src = (sh_in != CH_MONO && sh_en == EN_RIGHT) ? sr : sl;
            res.left  = apply_gain(src, g[0]);
            res.right = apply_gain(src, g[1]);
        end else begin
            res.left  = apply_gain(sl, g[0]);
            res.right = (sh_out == CH_STEREO) ? apply_gain(sr, g[1]) : '0;
        end
        nxt = int'(m_pos) + 1;
        if (nxt >= eff_len(sh_len)) begin
            res.block_end = 1'b1;
            m_pos = '0;
        end else begin
            m_pos = nxt[IDX_W-1:0];
        end
        return 1'b1;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(9))
            0: return SAT_MAX;
            1: return SAT_MIN;
            2: return '0;
            3: return '1;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_pan();
        case ($urandom_range(3))
            0: return '0;
            1: return UNITY_PAN;
            2: return '1;
            default: return CFG_W'($urandom_range(32768));
        endcase
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        t_plan_row r;
        r = '0;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        plan.push_back(r);
    endfunction

    function automatic void add_frame(input logic [SAMPLE_BITS-1:0] sl,
                                      input logic [SAMPLE_BITS-1:0] sr,
                                      input logic typed, input t_frame_out want);
        t_plan_row r;
        r = '0;
        r.kind  = ROW_FRAME;
        r.left  = sl;
        r.right = sr;
        r.typed = typed;
        r.want  = want;
        plan.push_back(r);
    endfunction

    function automatic void add_event(input logic req);
        t_plan_row r;
        r = '0;
        r.kind    = ROW_EVENT;
        r.request = req;
        plan.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
        fail_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MASTER:    sh_master = val;
            CFG_PAN_LEFT:  sh_pan_l  = val;
            CFG_PAN_RIGHT: sh_pan_r  = val;
            CFG_IN_CH:     sh_in     = val[1:0];
            CFG_OUT_CH:    sh_out    = val[1:0];
            CFG_EN_CH:     sh_en     = val[1:0];
            CFG_BLOCK_LEN: sh_len    = val[LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_item(input logic fn, input logic [SAMPLE_BITS-1:0] sl,
                             input logic [SAMPLE_BITS-1:0] sr, input logic req,
                             input logic typed, input t_frame_out typed_out);
        t_frame_out res;
        if (idle_en && $urandom_range(99) < 8) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(30, 1)) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_func           <= fn;
        i_sample_left    <= sl;
        i_sample_right   <= sr;
        i_active_request <= req;
        do @(posedge i_clk); while (!o_in_ready);
        if (advance_gain_model(fn, sl, sr, req, res)) begin
            expected_frames.push_back(typed ? typed_out : res);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            i_out_ready <= 1'b0;
            hold_ack    <= hold_req;
            hold_left   <= HOLD_CYCLES;
        end else begin
            i_out_ready <= !(idle_en && $urandom_range(99) < 8);
        end
    end

    always @(posedge i_clk) begin
        t_frame_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_frames.size() == 0) begin
                report_mismatch("unexpected frame, out_left", longint'($signed(o_out_left)), 0);
            end else begin
                want = expected_frames.pop_front();
                if (o_out_left !== want.left) begin
                    report_mismatch("out_left", longint'($signed(o_out_left)),
                                    longint'($signed(want.left)));
                end
                if (o_out_right !== want.right) begin
                    report_mismatch("out_right", longint'($signed(o_out_right)),
                                    longint'($signed(want.right)));
                end
                if (o_block_end !== want.block_end) begin
                    report_mismatch("block_end", longint'(o_block_end),
                                    longint'(want.block_end));
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int               ph;
        int               k;
        int               waited;
        logic [CFG_W-1:0] reg_val;

        add_frame(SAT_MAX, SAT_MIN, 1'b1, {24'd0, 24'd0, 1'b0});
        // Length zero acts as one and also ends the block that is already under way.
        add_cfg(CFG_BLOCK_LEN, 16'd0);
        add_frame(24'h000001, SAT_MIN, 1'b1, {24'd0, 24'd0, 1'b1});
        add_event(1'b1);
        add_frame(SAT_MAX, SAT_MAX, 1'b0, '0);
        add_frame(SAT_MAX, SAT_MIN, 1'b1, {SAT_MAX, SAT_MIN, 1'b1});
        add_cfg(CFG_MASTER, 16'hFFFF);
        add_frame(SAT_MAX, SAT_MIN, 1'b1, {SAT_MAX, SAT_MIN, 1'b1});
        add_frame(24'hFFFFFF, 24'h000001, 1'b0, '0);
        // Mono input, left pan gain above unity, right pan gain zero.
        add_cfg(CFG_IN_CH, CFG_W'(CH_MONO));
        add_cfg(CFG_PAN_LEFT, 16'hFFFF);
        add_cfg(CFG_PAN_RIGHT, 16'h0000);
        add_cfg(CFG_MASTER, 16'd4096);
        add_frame(24'h123456, 24'hABCDEF, 1'b0, '0);
        add_cfg(CFG_IN_CH, CFG_W'(CH_STEREO));
        add_cfg(CFG_EN_CH, CFG_W'(EN_RIGHT));
        add_cfg(CFG_PAN_LEFT, 16'd23170);
        add_cfg(CFG_PAN_RIGHT, UNITY_PAN);
        add_frame(24'h400000, 24'hC00000, 1'b0, '0);
        add_cfg(CFG_EN_CH, CFG_W'(EN_LEFT));
        add_frame(24'h7FF001, 24'h800FFF, 1'b0, '0);
        add_cfg(CFG_EN_CH, CFG_W'(CH_CODE_THREE));
        add_cfg(CFG_OUT_CH, CFG_W'(CH_MONO));
        add_frame(24'h2AAAAA, 24'h555555, 1'b0, '0);
        // Out-of-range codes and a block length above the maximum, then a fade-out.
        add_cfg(CFG_OUT_CH, CFG_W'(CH_CODE_ZERO));
        add_cfg(CFG_IN_CH, CFG_W'(CH_CODE_THREE));
        add_cfg(CFG_BLOCK_LEN, 16'd8191);
        add_event(1'b0);
        add_event(1'b0);
        add_frame(SAT_MAX, SAT_MIN, 1'b0, '0);
        add_frame(24'h654321, 24'h9ABCDE, 1'b0, '0);
        add_frame(24'hFFFFFF, 24'h000000, 1'b0, '0);
        // Shorter length mid-block: the block ends on the next frame.
        add_cfg(CFG_OUT_CH, CFG_W'(CH_STEREO));
        add_cfg(CFG_BLOCK_LEN, 16'd4);
        add_frame(24'h0F0F0F, 24'hF0F0F0, 1'b0, '0);
        add_event(1'b1);
        add_event(1'b1);
        add_frame(SAT_MAX, SAT_MIN, 1'b0, '0);
        add_frame(24'h333333, 24'hCCCCCC, 1'b0, '0);
        add_frame(24'h000001, 24'hFFFFFF, 1'b0, '0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_CFG: begin
                    wait_idle();
                    write_reg(plan[i].reg_idx, plan[i].reg_val);
                end
                ROW_FRAME: begin
                    send_item(FN_FRAME, plan[i].left, plan[i].right, 1'b0,
                              plan[i].typed, plan[i].want);
                end
                default: begin
                    send_item(FN_SET_ACTIVE, rand_sample(), rand_sample(), plan[i].request,
                              1'b0, '0);
                end
            endcase
        end

        for (ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            idle_en <= (ph != 3 && ph != 4);
            case ($urandom_range(3))
                0: reg_val = '0;
                1: reg_val = '1;
                2: reg_val = 16'd4096;
                default: reg_val = CFG_W'($urandom_range(65535));
            endcase
            write_reg(CFG_MASTER, reg_val);
            write_reg(CFG_PAN_LEFT, rand_pan());
            write_reg(CFG_PAN_RIGHT, rand_pan());
            write_reg(CFG_IN_CH, CFG_W'($urandom_range(3)));
            write_reg(CFG_OUT_CH, CFG_W'($urandom_range(3)));
            write_reg(CFG_EN_CH, CFG_W'($urandom_range(3)));
            case ($urandom_range(9))
                0: reg_val = 16'd0;
                1: reg_val = 16'd4096;
                2: reg_val = 16'd8191;
                3: reg_val = CFG_W'($urandom_range(64, 16));
                default: reg_val = CFG_W'($urandom_range(8, 1));
            endcase
            if (ph == 0) begin
                reg_val = 16'd4;
            end
            // A large stretch of a block under way would push the ramp past the gain range.
            if (m_pos != '0 && eff_len(reg_val[LEN_W-1:0]) > 256 * m_latched_len) begin
                reg_val = CFG_W'(m_latched_len);
            end
            write_reg(CFG_BLOCK_LEN, reg_val);
            if (ph == 1 || ph == 7) begin
                hold_req <= hold_req + 1;
            end
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(99) < 12) begin
                    send_item(FN_SET_ACTIVE, rand_sample(), rand_sample(),
                              ($urandom_range(3) == 0) ? m_active : !m_active, 1'b0, '0);
                end else begin
                    send_item(FN_FRAME, rand_sample(), rand_sample(),
                              1'($urandom_range(1)), 1'b0, '0);
                end
            end
        end

        i_in_valid <= 1'b0;
        waited = 0;
        while (expected_frames.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_frames.size() != 0) begin
            report_mismatch("frames never produced", 0, longint'(expected_frames.size()));
        end
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ fade_pan_gain_stage.f @@
rtl/core/fpg_pkg.sv
rtl/core/fpg_lane.sv
rtl/core/fade_pan_gain_stage.sv
rtl/core/fpg_checker.sv
tb/tb_fade_pan_gain_stage.sv
